[design/nmea_sentence_deframer_top_defines.svh]
// Assertion macros shared by the sentence deframer RTL.
`ifndef NMEA_SENTENCE_DEFRAMER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_DEFRAMER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define NSD_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`define NSD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define NSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NSD_ASSERT_NEVER(lbl, expr, msg)
`define NSD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define NSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/nsd_pkg.sv]
// Shared constants, types and helpers of the sentence deframer.
`default_nettype none

package nsd_pkg;

    localparam int BUFFER_LENGTH = 64;
    localparam int STORE_DEPTH   = 64;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int COUNT_W       = 7;

    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] DIGIT_TEN    = 8'd10;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [1:0] PREFIX_RESET = 2'd2;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic load_byte;
        logic load_flag;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic ev_done;
        logic ev_ovf;
        logic done_len_zero;
        logic out_free;
        logic last_byte;
    } sts_t;

    // Returns {invalid, nibble}.
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [7:0] v;
        logic       bad;
        v   = 8'd0;
        bad = 1'b0;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            v = ch - CHAR_ZERO;
        end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) begin
            v = ch - CHAR_UPPER_A + DIGIT_TEN;
        end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F) begin
            v = ch - CHAR_LOWER_A + DIGIT_TEN;
        end else begin
            bad = 1'b1;
        end
        return {bad, v[3:0]};
    endfunction

endpackage

`default_nettype wire

[design/nsd_datapath.sv]
// Datapath: phase tracking, checksum, sentence store and output register.
`default_nettype none

module nsd_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic [1:0]                    cfg_data,
    input  wire logic [7:0]                    s_char_in,
    input  wire logic                          m_ready,
    input  wire nsd_pkg::cmd_t                 cmd,
    output nsd_pkg::sts_t                      sts,
    output logic                               m_valid,
    output logic [7:0]                         m_payload_byte,
    output logic                               m_has_byte,
    output logic                               m_last,
    output logic [1:0]                         m_status,
    output logic [nsd_pkg::COUNT_W-1:0]        m_payload_length
);

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_BODY = 4'b0010,
        PH_DIG1 = 4'b0100,
        PH_DIG2 = 4'b1000
    } phase_t;

    localparam int CW = nsd_pkg::COUNT_W;
    localparam int AW = nsd_pkg::ADDR_W;

    phase_t          phase_reg, phase_next;
    logic [7:0]      xor_reg, xor_next;
    logic [3:0]      nibble_reg, nibble_next;
    logic            bad_reg, bad_next;
    logic [CW-1:0]   stored_count_reg, stored_count_next;
    logic [CW-1:0]   char_count_reg, char_count_next;
    logic [1:0]      prefix_reg;
    logic [1:0]      st_reg, st_next;
    logic [CW-1:0]   len_reg, len_next;
    logic [AW-1:0]   rd_idx_reg, rd_idx_next;
    logic [CW-1:0]   emit_cnt_reg, emit_cnt_next;
    logic [7:0]      rd_data_reg;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      out_byte_reg;
    logic            out_has_reg;
    logic            out_last_reg;
    logic [1:0]      out_st_reg;
    logic [CW-1:0]   out_len_reg;
    logic [7:0]      store_mem [nsd_pkg::STORE_DEPTH];

    logic [4:0]      hex;
    logic [7:0]      rx_sum;
    logic [CW-1:0]   cnt_inc;
    logic [CW-1:0]   done_len;
    logic            wr_en;
    logic            out_load;
    logic            mid_ok;
    logic            store_over;

    // Status to ctrl uses registers only; out_free also follows m_ready.
    always_comb begin
        hex      = nsd_pkg::hex_value(s_char_in);
        rx_sum   = {nibble_reg, hex[3:0]};
        cnt_inc  = char_count_reg + CW'(1);
        done_len = (stored_count_reg > {{(CW-2){1'b0}}, prefix_reg})
                 ? stored_count_reg - {{(CW-2){1'b0}}, prefix_reg} : '0;

        sts.ev_done       = (phase_reg == PH_DIG2);
        sts.ev_ovf        = (phase_reg != PH_DIG2) && (cnt_inc >= CW'(nsd_pkg::BUFFER_LENGTH));
        sts.done_len_zero = (done_len == '0);
        sts.out_free      = !m_valid_reg || m_ready;
        sts.last_byte     = (emit_cnt_reg + CW'(1)) == len_reg;
    end

    assign out_load = cmd.load_byte || cmd.load_flag;

    always_comb begin
        phase_next        = phase_reg;
        xor_next          = xor_reg;
        nibble_next       = nibble_reg;
        bad_next          = bad_reg;
        stored_count_next = stored_count_reg;
        char_count_next   = char_count_reg;
        st_next           = st_reg;
        len_next          = len_reg;
        rd_idx_next       = rd_idx_reg;
        emit_cnt_next     = emit_cnt_reg;
        wr_en             = 1'b0;

        if (cmd.accept) begin
            if (sts.ev_done) begin
                st_next = (bad_reg || hex[4] || rx_sum != xor_reg)
                        ? nsd_pkg::STATUS_CHECKSUM : nsd_pkg::STATUS_OK;
                len_next        = done_len;
                rd_idx_next     = {{(AW-2){1'b0}}, prefix_reg};
                emit_cnt_next   = '0;
                phase_next      = PH_HUNT;
                char_count_next = '0;
            end else if (sts.ev_ovf) begin
                st_next         = nsd_pkg::STATUS_OVERFLOW;
                len_next        = '0;
                phase_next      = PH_HUNT;
                char_count_next = '0;
            end else begin
                char_count_next = cnt_inc;
                case (phase_reg)
                    PH_HUNT: begin
                        if (s_char_in == nsd_pkg::CHAR_DOLLAR) begin
                            phase_next        = PH_BODY;
                            xor_next          = 8'd0;
                            stored_count_next = '0;
                        end
                    end
                    PH_BODY: begin
                        if (s_char_in == nsd_pkg::CHAR_STAR) begin
                            phase_next = PH_DIG1;
                        end else begin
                            xor_next = xor_reg ^ s_char_in;
                            if (stored_count_reg < CW'(nsd_pkg::STORE_DEPTH)) begin
                                wr_en             = 1'b1;
                                stored_count_next = stored_count_reg + CW'(1);
                            end
                        end
                    end
                    default: begin
                        bad_next    = hex[4];
                        nibble_next = hex[3:0];
                        phase_next  = PH_DIG2;
                    end
                endcase
            end
        end

        // Advance the read pointer as each byte leaves.
        if (cmd.load_byte) begin
            rd_idx_next   = rd_idx_reg + AW'(1);
            emit_cnt_next = emit_cnt_reg + CW'(1);
        end

        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            xor_reg          <= 8'd0;
            nibble_reg       <= 4'd0;
            bad_reg          <= 1'b0;
            stored_count_reg <= '0;
            char_count_reg   <= '0;
            prefix_reg       <= nsd_pkg::PREFIX_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            xor_reg          <= xor_next;
            nibble_reg       <= nibble_next;
            bad_reg          <= bad_next;
            stored_count_reg <= stored_count_next;
            char_count_reg   <= char_count_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_valid) begin
                prefix_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        st_reg       <= st_next;
        len_reg      <= len_next;
        rd_idx_reg   <= rd_idx_next;
        emit_cnt_reg <= emit_cnt_next;
        if (cmd.load_byte) begin
            out_byte_reg <= rd_data_reg;
            out_has_reg  <= 1'b1;
            out_last_reg <= sts.last_byte;
            out_st_reg   <= sts.last_byte ? st_reg : nsd_pkg::STATUS_OK;
            out_len_reg  <= sts.last_byte ? len_reg : '0;
        end else if (cmd.load_flag) begin
            out_byte_reg <= 8'd0;
            out_has_reg  <= 1'b0;
            out_last_reg <= 1'b1;
            out_st_reg   <= st_reg;
            out_len_reg  <= '0;
        end
    end

    // Sentence store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[stored_count_reg[AW-1:0]] <= s_char_in;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[rd_idx_reg];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_payload_byte   = out_byte_reg;
    assign m_has_byte       = out_has_reg;
    assign m_last           = out_last_reg;
    assign m_status         = out_st_reg;
    assign m_payload_length = out_len_reg;

    assign mid_ok     = out_has_reg && (out_st_reg == nsd_pkg::STATUS_OK) && (out_len_reg == '0);
    assign store_over = (stored_count_reg >= CW'(nsd_pkg::BUFFER_LENGTH));

    `include "nmea_sentence_deframer_top_defines.svh"

    `NSD_ASSERT_NEVER(a_no_overwrite, out_load && m_valid_reg && !m_ready, "result overwritten")
    `NSD_ASSERT_IMPLY(a_mid_clear, m_valid_reg && !out_last_reg, mid_ok, "mid result fields set")
    `NSD_ASSERT_NEVER(a_store_bound, store_over, "stored count reached buffer length")

endmodule

`default_nettype wire

[design/nsd_ctrl.sv]
// Controller: accepts characters and sequences the result burst.
`default_nettype none

module nsd_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire nsd_pkg::sts_t sts,
    output nsd_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_FLAG = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        accept        = s_valid && s_ready;
        cmd.accept    = accept;
        cmd.rd_en     = 1'b0;
        cmd.load_byte = 1'b0;
        cmd.load_flag = 1'b0;
        state_next    = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (sts.ev_ovf || (sts.ev_done && sts.done_len_zero)) begin
                        state_next = ST_FLAG;
                    end else if (sts.ev_done) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_byte = 1'b1;
                    state_next    = sts.last_byte ? ST_IDLE : ST_READ;
                end
            end
            ST_FLAG: begin
                if (sts.out_free) begin
                    cmd.load_flag = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `include "nmea_sentence_deframer_top_defines.svh"

    `NSD_ASSERT_NEXT(a_done_leaves_idle, accept && sts.ev_done, state_reg != ST_IDLE, "completed sentence did not start emission")
    `NSD_ASSERT_IMPLY(a_read_then_emit, state_reg == ST_READ, state_next == ST_EMIT, "store read not followed by emit")

endmodule

`default_nettype wire

[design/nmea_sentence_deframer_top.sv]
// Top level of the NMEA sentence deframer.
// Usage:
//   s_* channel: one received character per request (s_char_in). Characters
//     are dropped until '$'; the body up to '*' is stored and XORed, then two
//     hex checksum digits follow, in either case.
//   m_* channel: results. On the second checksum digit the stored body, less
//     the first prefix_skip characters, leaves one byte per request; the final
//     one has m_last set with status (ok or checksum error) and the length.
//     A sentence with no payload gives one status-only request. When the
//     character count since the last sentence reaches the buffer length, one
//     overflow request (status 2, no byte) is sent and hunting resumes.
//   cfg_* channel: writes prefix_skip (2 bits, reset 2); always ready. Write
//     it only while the block is idle.
// Sequencing: a character that yields no result leaves the block ready for
//   the next one. A burst reads each byte from the store, then loads it into
//   the output register, as the store has one read port; a status-only result
//   needs no store read. The next character is taken when the burst ends.
// Reset (aresetn low, synchronous) returns to hunting; char counts cleared.
// A stalled receiver (m_ready low) holds the output register and the burst
//   sequencer; no request is lost or repeated.
`default_nettype none

module nmea_sentence_deframer_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_payload_byte,
    output logic            m_has_byte,
    output logic            m_last,
    output logic [1:0]      m_status,
    output logic [6:0]      m_payload_length
);

    nsd_pkg::cmd_t cmd;
    nsd_pkg::sts_t sts;

    // Configuration register is a plain flop: accept writes every cycle.
    assign cfg_ready = 1'b1;

    nsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    nsd_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .s_char_in        (s_char_in),
        .m_ready          (m_ready),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_payload_byte   (m_payload_byte),
        .m_has_byte       (m_has_byte),
        .m_last           (m_last),
        .m_status         (m_status),
        .m_payload_length (m_payload_length)
    );

endmodule

`default_nettype wire
